// ===== design/io_port_decode_and_paging_latch_defines.svh =====
// ----------------------------------------------------------------------------
// I/O port decode and paging latch: assertion macros
// Shared property wrappers for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef IO_PORT_DECODE_AND_PAGING_LATCH_DEFINES_SVH
`define IO_PORT_DECODE_AND_PAGING_LATCH_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, quiet while in reset
`define IOPD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("io port decode check failed");

// Next-cycle implication, sampled on clk_i, quiet while in reset
`define IOPD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("io port decode check failed");

`endif

// ===== design/iopd_pkg.sv =====
// ----------------------------------------------------------------------------
// I/O port decode package
// Port codes, decode table and types shared by the decode and paging logic.
// ----------------------------------------------------------------------------
package iopd_pkg;

  // Resolved port codes
  localparam logic [15:0] PORT_NONE = 16'h0000;
  localparam logic [15:0] PORT_FFFD = 16'hFFFD;
  localparam logic [15:0] PORT_BFFD = 16'hBFFD;
  localparam logic [15:0] PORT_7FFD = 16'h7FFD;
  localparam logic [15:0] PORT_FE   = 16'h00FE;
  localparam logic [15:0] PORT_FF   = 16'h00FF;

  // Disk port family: match on low bits, select from bits 5-6
  localparam logic [15:0] DISK_MASK  = 16'h0083;
  localparam logic [15:0] DISK_MATCH = 16'h0003;
  localparam logic [15:0] DISK_SEL   = 16'h0060;
  localparam logic [15:0] DISK_LOW   = 16'h001F;

  localparam int unsigned NUM_RULES = 5;

  // Access kinds
  localparam logic KIND_READ  = 1'b0;
  localparam logic KIND_WRITE = 1'b1;

  // Read data when the block does not own the port
  localparam logic [7:0] READ_IDLE = 8'hFF;

  // ROM pages and paging byte fields
  localparam logic [1:0] ROM_128   = 2'd2;
  localparam logic [1:0] ROM_48    = 2'd3;
  localparam int unsigned SCREEN_BIT = 3;
  localparam int unsigned ROM_BIT    = 4;
  localparam int unsigned LOCK_BIT   = 5;

  typedef struct packed {
    logic [15:0] mask;
    logic [15:0] match;
    logic [15:0] code;
  } port_rule_t;

  // Priority order: first entry wins
  localparam port_rule_t RULES [NUM_RULES] = '{
    '{mask: 16'hC002, match: 16'hC000, code: PORT_FFFD},
    '{mask: 16'hC002, match: 16'h8000, code: PORT_BFFD},
    '{mask: 16'h8002, match: 16'h0000, code: PORT_7FFD},
    '{mask: 16'h0001, match: 16'h0000, code: PORT_FE},
    '{mask: 16'h0083, match: 16'h0083, code: PORT_FF}
  };

  // Decode result
  typedef struct packed {
    logic [15:0] code;
    logic        hit;
  } iopd_dec_t;

  // Paging state as seen after the current access
  typedef struct packed {
    logic [1:0] rom_page;
    logic [2:0] ram_page_top;
    logic       screen_sel;
    logic       screen_changed;
    logic       locked;
  } iopd_view_t;

endpackage

// ===== design/io_port_decode_and_paging_latch.sv =====
// ----------------------------------------------------------------------------
// I/O port decode and paging latch
// Datapath: an accepted input word is held in the input register, then
// moves on to the result register.
// Throughput: one word per cycle while the receiver takes result words;
// decode and latch update fit one stage between the input and result registers.
// Reset: clears both stage valids, latch to 0, unlocked, ROM page 2, RAM page 0.
// ----------------------------------------------------------------------------
module io_port_decode_and_paging_latch
  import iopd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        kind_i,
  input  logic [15:0] port_address_i,
  input  logic [7:0]  write_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] decoded_port_o,
  output logic [7:0]  read_data_o,
  output logic        local_hit_o,
  output logic [1:0]  rom_page_o,
  output logic [2:0]  ram_page_top_o,
  output logic        screen_sel_o,
  output logic        screen_changed_o,
  output logic        paging_locked_o
);

  logic        stage_valid_q, stage_valid_d;
  logic        kind_q;
  logic [15:0] addr_q;
  logic [7:0]  data_q;
  logic        out_valid_q, out_valid_d;
  logic        out_free;
  logic        advance;
  logic        in_fire;

  iopd_dec_t   dec;
  iopd_view_t  view;
  logic [7:0]  paging_value;
  logic [7:0]  read_data;

  logic [15:0] res_port_q;
  logic [7:0]  res_read_q;
  logic        res_hit_q;
  iopd_view_t  res_view_q;

  // Handshake: result slot frees when empty or taken
  assign out_free   = !out_valid_q || out_ready_i;
  assign advance    = stage_valid_q && out_free;
  assign in_ready_o = !stage_valid_q || out_free;
  assign in_fire    = in_valid_i && in_ready_o;

  // Input register valid
  always_comb begin
    stage_valid_d = stage_valid_q;
    if (in_fire) begin
      stage_valid_d = 1'b1;
    end else if (advance) begin
      stage_valid_d = 1'b0;
    end
  end

  // Result register valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_valid_q <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      stage_valid_q <= stage_valid_d;
      out_valid_q   <= out_valid_d;
    end
  end

  // Capture the input word
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      kind_q <= kind_i;
      addr_q <= port_address_i;
      data_q <= write_data_i;
    end
  end

  iopd_decoder u_decoder (
    .port_address_i (addr_q),
    .dec_o          (dec)
  );

  iopd_latch u_latch (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .wr_en_i        (advance && dec.hit && (kind_q == KIND_WRITE)),
    .data_i         (data_q),
    .paging_value_o (paging_value),
    .view_o         (view)
  );

  // Read back the latch only on a 7FFD read
  assign read_data = (dec.hit && (kind_q == KIND_READ)) ? paging_value : READ_IDLE;

  // Load the result word
  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_port_q <= dec.code;
      res_read_q <= read_data;
      res_hit_q  <= dec.hit;
      res_view_q <= view;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign decoded_port_o   = res_port_q;
  assign read_data_o      = res_read_q;
  assign local_hit_o      = res_hit_q;
  assign rom_page_o       = res_view_q.rom_page;
  assign ram_page_top_o   = res_view_q.ram_page_top;
  assign screen_sel_o     = res_view_q.screen_sel;
  assign screen_changed_o = res_view_q.screen_changed;
  assign paging_locked_o  = res_view_q.locked;

endmodule

// ===== design/iopd_decoder.sv =====
// ----------------------------------------------------------------------------
// I/O port address decoder
// Resolves a 16-bit port address through the priority mask/match table.
// ----------------------------------------------------------------------------
module iopd_decoder
  import iopd_pkg::*;
(
  input  logic [15:0] port_address_i,
  output iopd_dec_t   dec_o
);

  logic [15:0] code;

  // Walk the table from lowest priority up so the first matching rule wins
  always_comb begin
    if ((port_address_i & DISK_MASK) == DISK_MATCH) begin
      code = (port_address_i & DISK_SEL) | DISK_LOW;
    end else begin
      code = PORT_NONE;
    end
    for (int i = NUM_RULES - 1; i >= 0; i--) begin
      if ((port_address_i & RULES[i].mask) == RULES[i].match) begin
        code = RULES[i].code;
      end
    end
  end

  assign dec_o.code = code;
  assign dec_o.hit  = (code == PORT_7FFD);

endmodule

// ===== design/iopd_latch.sv =====
// ----------------------------------------------------------------------------
// Paging latch
// Holds the 7FFD byte, lock, ROM page and top RAM page; applies port writes.
// ----------------------------------------------------------------------------
module iopd_latch
  import iopd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       wr_en_i,
  input  logic [7:0] data_i,
  output logic [7:0] paging_value_o,
  output iopd_view_t view_o
);

  logic [7:0] paging_q, paging_d;
  logic       lock_q, lock_d;
  logic [1:0] rom_q, rom_d;
  logic [2:0] ram_q, ram_d;
  logic       changed;

  // Apply a 7FFD write; locked paging forces the 48K map
  always_comb begin
    paging_d = paging_q;
    lock_d   = lock_q;
    rom_d    = rom_q;
    ram_d    = ram_q;
    changed  = 1'b0;
    if (wr_en_i) begin
      if (!lock_q) begin
        ram_d  = data_i[2:0];
        rom_d  = ROM_128 | {1'b0, data_i[ROM_BIT]};
        lock_d = data_i[LOCK_BIT];
      end else begin
        ram_d = '0;
        rom_d = ROM_48;
      end
      changed  = paging_q[SCREEN_BIT] ^ data_i[SCREEN_BIT];
      paging_d = data_i;
    end
  end

  // Hold state; next value equals current when no write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      paging_q <= '0;
      lock_q   <= 1'b0;
      rom_q    <= ROM_128;
      ram_q    <= '0;
    end else begin
      paging_q <= paging_d;
      lock_q   <= lock_d;
      rom_q    <= rom_d;
      ram_q    <= ram_d;
    end
  end

  assign paging_value_o        = paging_q;
  assign view_o.rom_page       = rom_d;
  assign view_o.ram_page_top   = ram_d;
  assign view_o.screen_sel     = paging_d[SCREEN_BIT];
  assign view_o.screen_changed = changed;
  assign view_o.locked         = lock_d;

endmodule

// ===== design/iopd_checker.sv =====
// ----------------------------------------------------------------------------
// I/O port decode port checker
// Port-level properties of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "io_port_decode_and_paging_latch_defines.svh"

module iopd_checker
  import iopd_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [15:0] decoded_port_o,
  input logic [7:0]  read_data_o,
  input logic        local_hit_o,
  input logic        screen_changed_o,
  input logic        paging_locked_o
);

  // Local hit only for the paging port, and foreign ports read idle
  `IOPD_ASSERT_NOW(a_hit_code, out_valid_o && local_hit_o, decoded_port_o == PORT_7FFD)
  `IOPD_ASSERT_NOW(a_idle_read, out_valid_o && !local_hit_o, read_data_o == READ_IDLE)
  // Screen change comes only from a paging port access
  `IOPD_ASSERT_NOW(a_change_hit, out_valid_o && screen_changed_o, local_hit_o)
  // Lock stays set until reset
  `IOPD_ASSERT_NEXT(a_lock_sticky, out_valid_o && paging_locked_o,
                    !out_valid_o || paging_locked_o)
  // Stalled result word holds
  `IOPD_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i,
                    out_valid_o && $stable(decoded_port_o))

endmodule

bind io_port_decode_and_paging_latch iopd_checker u_iopd_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .decoded_port_o   (decoded_port_o),
  .read_data_o      (read_data_o),
  .local_hit_o      (local_hit_o),
  .screen_changed_o (screen_changed_o),
  .paging_locked_o  (paging_locked_o)
);

// ===== bench/io_port_decode_and_paging_latch_tb.sv =====
// ----------------------------------------------------------------------------
// I/O port decode and paging latch testbench
// Sends directed and random port accesses through the valid/ready input.
// A local model of the decoder and the paging latch predicts each result
// word, and the scoreboard checks the result words in order, field by field.
// Both sides stall at random, and one long receiver stall backs up the input.
// ----------------------------------------------------------------------------

// One expected or observed result word
typedef struct packed {
  logic [15:0] decoded_port;
  logic [7:0]  read_data;
  logic        local_hit;
  logic [1:0]  rom_page;
  logic [2:0]  ram_page_top;
  logic        screen_sel;
  logic        screen_changed;
  logic        paging_locked;
} access_result_t;

// Paging latch model plus the queue of result words still owed by the block
class paging_scoreboard;
  logic [7:0]     latch_value;
  logic           lock_set;
  logic [1:0]     rom_sel;
  logic [2:0]     ram_sel;
  access_result_t expected_results[$];
  int unsigned    errors;

  function new();
    latch_value = 8'h00;
    lock_set    = 1'b0;
    rom_sel     = iopd_pkg::ROM_128;
    ram_sel     = 3'd0;
    errors      = 0;
  endfunction

  // Resolve an address in priority order: FFFD, BFFD, 7FFD first, then ULA, FF, disk
  function logic [15:0] resolve_port(logic [15:0] addr);
    logic [15:0] disk_code;
    disk_code      = 16'h001F;
    disk_code[6:5] = addr[6:5];
    if (addr[15:14] == 2'b11 && !addr[1]) return iopd_pkg::PORT_FFFD;
    if (addr[15:14] == 2'b10 && !addr[1]) return iopd_pkg::PORT_BFFD;
    if (!addr[15] && !addr[1])            return iopd_pkg::PORT_7FFD;
    if (!addr[0])                         return iopd_pkg::PORT_FE;
    if (addr[7] && addr[1] && addr[0])    return iopd_pkg::PORT_FF;
    if (!addr[7] && addr[1] && addr[0])   return disk_code;
    return iopd_pkg::PORT_NONE;
  endfunction

  // Advance the model by one accepted access and queue its result word
  function void note_access(logic kind, logic [15:0] addr, logic [7:0] data);
    access_result_t want;
    want.decoded_port   = resolve_port(addr);
    want.local_hit      = (want.decoded_port == iopd_pkg::PORT_7FFD);
    want.read_data      = iopd_pkg::READ_IDLE;
    want.screen_changed = 1'b0;
    if (want.local_hit && kind == iopd_pkg::KIND_READ) begin
      want.read_data = latch_value;
    end else if (want.local_hit) begin
      // once locked, force the 48K layout on every paging write
      if (!lock_set) begin
        ram_sel  = data[2:0];
        rom_sel  = iopd_pkg::ROM_128 | {1'b0, data[iopd_pkg::ROM_BIT]};
        lock_set = data[iopd_pkg::LOCK_BIT];
      end else begin
        ram_sel = 3'd0;
        rom_sel = iopd_pkg::ROM_48;
      end
      want.screen_changed = latch_value[iopd_pkg::SCREEN_BIT] ^ data[iopd_pkg::SCREEN_BIT];
      latch_value = data;
    end
    want.rom_page      = rom_sel;
    want.ram_page_top  = ram_sel;
    want.screen_sel    = latch_value[iopd_pkg::SCREEN_BIT];
    want.paging_locked = lock_set;
    expected_results.push_back(want);
  endfunction

  task report(string field, logic [15:0] got, logic [15:0] want);
    $display("[%0t] mismatch on %s: got %h, expected %h", $time, field, got, want);
    errors++;
  endtask

  // Compare one result word with the oldest prediction
  task check_result(access_result_t got);
    access_result_t want;
    if (expected_results.size() == 0) begin
      report("unexpected word", got.decoded_port, 16'h0000);
    end else begin
      want = expected_results.pop_front();
      if (got.decoded_port !== want.decoded_port)
        report("decoded_port", got.decoded_port, want.decoded_port);
      if (got.read_data !== want.read_data)
        report("read_data", 16'(got.read_data), 16'(want.read_data));
      if (got.local_hit !== want.local_hit)
        report("local_hit", 16'(got.local_hit), 16'(want.local_hit));
      if (got.rom_page !== want.rom_page)
        report("rom_page", 16'(got.rom_page), 16'(want.rom_page));
      if (got.ram_page_top !== want.ram_page_top)
        report("ram_page_top", 16'(got.ram_page_top), 16'(want.ram_page_top));
      if (got.screen_sel !== want.screen_sel)
        report("screen_sel", 16'(got.screen_sel), 16'(want.screen_sel));
      if (got.screen_changed !== want.screen_changed)
        report("screen_changed", 16'(got.screen_changed), 16'(want.screen_changed));
      if (got.paging_locked !== want.paging_locked)
        report("paging_locked", 16'(got.paging_locked), 16'(want.paging_locked));
    end
  endtask
endclass

module io_port_decode_and_paging_latch_tb;
  import iopd_pkg::*;

  localparam int unsigned CYCLE_LIMIT     = 400000;
  localparam int unsigned RANDOM_UNLOCKED = 1100;
  localparam int unsigned RANDOM_LOCKED   = 230;
  localparam int unsigned QUIET_TAIL      = 150;
  localparam int unsigned HOLD_AT         = 300;
  localparam int unsigned HOLD_OFF_CYCLES = 120;
  localparam int unsigned DRAIN_CYCLES    = 8;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic        kind_i;
  logic [15:0] port_address_i;
  logic [7:0]  write_data_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [15:0] decoded_port_o;
  logic [7:0]  read_data_o;
  logic        local_hit_o;
  logic [1:0]  rom_page_o;
  logic [2:0]  ram_page_top_o;
  logic        screen_sel_o;
  logic        screen_changed_o;
  logic        paging_locked_o;

  paging_scoreboard paging_sb;
  bit               quiet    = 1'b0;
  bit               hold_req = 1'b0;
  bit               holding  = 1'b0;
  int unsigned      cycles   = 0;

  io_port_decode_and_paging_latch u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .kind_i           (kind_i),
    .port_address_i   (port_address_i),
    .write_data_i     (write_data_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .decoded_port_o   (decoded_port_o),
    .read_data_o      (read_data_o),
    .local_hit_o      (local_hit_o),
    .rom_page_o       (rom_page_o),
    .ram_page_top_o   (ram_page_top_o),
    .screen_sel_o     (screen_sel_o),
    .screen_changed_o (screen_changed_o),
    .paging_locked_o  (paging_locked_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Offer one word and hold it until the block takes it
  task automatic send_word(logic kind, logic [15:0] addr, logic [7:0] data);
    @(negedge clk_i);
    in_valid_i     <= 1'b1;
    kind_i         <= kind;
    port_address_i <= addr;
    write_data_i   <= data;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic pause_sender(int unsigned span);
    repeat (span) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
  endtask

  // Random access; most land in the paging port's address family
  task automatic send_random(bit keep_unlocked);
    logic        kind;
    logic [15:0] addr;
    logic [7:0]  data;
    int unsigned pick;
    pick = $urandom_range(0, 9);
    addr = 16'($urandom_range(0, 16'hFFFF));
    if (pick < 4) begin
      addr[15] = 1'b0;
      addr[1]  = 1'b0;
    end else if (pick == 4) begin
      case ($urandom_range(0, 5))
        0: addr = PORT_FFFD;
        1: addr = PORT_BFFD;
        2: addr = PORT_7FFD;
        3: addr = PORT_FE;
        4: addr = PORT_FF;
        default: begin
          addr      = 16'h001F;
          addr[6:5] = 2'($urandom_range(0, 3));
        end
      endcase
    end
    kind = 1'($urandom_range(0, 1));
    data = 8'($urandom_range(0, 255));
    // keep the lock clear until the locked phase
    if (keep_unlocked && kind == KIND_WRITE && paging_sb.resolve_port(addr) == PORT_7FFD)
      data[LOCK_BIT] = 1'b0;
    if (!quiet && !hold_req && !holding && $urandom_range(0, 7) == 0)
      pause_sender($urandom_range(1, 18));
    send_word(kind, addr, data);
  endtask

  // Stimulus
  initial begin
    paging_sb      = new();
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    kind_i         = KIND_READ;
    port_address_i = 16'h0000;
    write_data_i   = 8'h00;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // decode of every port family and the address extremes
    send_word(KIND_READ,  16'h0000,  8'h00);
    send_word(KIND_READ,  16'hFFFF,  8'hFF);
    send_word(KIND_READ,  PORT_FFFD, 8'h00);
    send_word(KIND_READ,  PORT_BFFD, 8'h00);
    send_word(KIND_READ,  PORT_FE,   8'h00);
    send_word(KIND_READ,  PORT_FF,   8'h00);
    send_word(KIND_READ,  16'h001F,  8'h00);
    send_word(KIND_READ,  16'h003F,  8'h00);
    send_word(KIND_READ,  16'h005F,  8'h00);
    send_word(KIND_READ,  16'h007F,  8'h00);
    // paging writes: top page, ROM select, screen toggle and no toggle
    send_word(KIND_WRITE, PORT_7FFD, 8'h17);
    send_word(KIND_READ,  PORT_7FFD, 8'hFF);
    send_word(KIND_WRITE, PORT_7FFD, 8'h08);
    send_word(KIND_WRITE, PORT_7FFD, 8'hC8);
    send_word(KIND_WRITE, PORT_FFFD, 8'hFF);
    send_word(KIND_WRITE, PORT_FE,   8'h20);
    send_word(KIND_WRITE, 16'h7FFF,  8'h07);
    send_word(KIND_READ,  PORT_7FFD, 8'h00);

    for (int unsigned i = 0; i < RANDOM_UNLOCKED; i++) begin
      if (i == HOLD_AT) hold_req = 1'b1;
      send_random(1'b1);
    end

    // set the lock, then page while locked
    send_word(KIND_WRITE, PORT_7FFD, 8'h3F);
    send_word(KIND_WRITE, PORT_7FFD, 8'h00);
    send_word(KIND_WRITE, PORT_7FFD, 8'h17);
    send_word(KIND_READ,  PORT_7FFD, 8'h00);

    for (int unsigned i = 0; i < RANDOM_LOCKED; i++) begin
      if (i == RANDOM_LOCKED - QUIET_TAIL) quiet = 1'b1;
      send_random(1'b0);
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (paging_sb.expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (paging_sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Receiver: random stalls, one long hold-off on request, none at the tail
  initial begin
    int unsigned span;
    logic        level;
    level       = 1'b0;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        holding  = 1'b1;
        level    = 1'b0;
        span     = HOLD_OFF_CYCLES;
      end else begin
        holding = 1'b0;
        if (quiet || $urandom_range(0, 2) != 0) begin
          level = 1'b1;
          span  = $urandom_range(1, 40);
        end else begin
          level = 1'b0;
          span  = $urandom_range(1, 18);
        end
      end
      repeat (span) begin
        @(negedge clk_i);
        out_ready_i <= level;
      end
    end
  end

  // Note accepted accesses, check accepted result words
  always @(posedge clk_i) begin
    access_result_t got;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o)
        paging_sb.note_access(kind_i, port_address_i, write_data_i);
      if (out_valid_o && out_ready_i) begin
        got = {decoded_port_o, read_data_o, local_hit_o, rom_page_o, ram_page_top_o,
               screen_sel_o, screen_changed_o, paging_locked_o};
        paging_sb.check_result(got);
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

endmodule
